>>> rtl/core/pcrc_pkg.sv
// Types, constants and the comparison helper for the password class-ratio checker.
// No dependencies; imported by password_class_ratio_checker_top.
package pcrc_pkg;

  localparam int unsigned MAX_LEN = 255;
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned THR_W   = FRAC_W + 1;
  localparam int unsigned PROD_W  = THR_W + CNT_W;
  localparam int unsigned LIM_W   = 9;
  localparam int unsigned LCMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam int unsigned CODE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = THR_W;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VERD_W  = 3;
  localparam int unsigned TLEN_W  = 8;

  localparam logic [BYTE_W-1:0] UPPER_LO = 8'd65;
  localparam logic [BYTE_W-1:0] UPPER_HI = 8'd90;
  localparam logic [BYTE_W-1:0] LOWER_LO = 8'd97;
  localparam logic [BYTE_W-1:0] LOWER_HI = 8'd122;
  localparam logic [BYTE_W-1:0] DIGIT_LO = 8'd48;
  localparam logic [BYTE_W-1:0] DIGIT_HI = 8'd57;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH_TEST     = 3'd0,
    REG_LENGTH_LIMIT    = 3'd1,
    REG_RATIO_TESTS     = 3'd2,
    REG_ALPHA_THRESHOLD = 3'd3,
    REG_DIGIT_THRESHOLD = 3'd4,
    REG_OTHER_THRESHOLD = 3'd5,
    REG_CASE_THRESHOLD  = 3'd6
  } cfg_reg_e;

  typedef enum logic [CODE_W-1:0] {
    CMP_NONE = 3'd0,
    CMP_LT   = 3'd1,
    CMP_LE   = 3'd2,
    CMP_EQ   = 3'd3,
    CMP_GT   = 3'd4,
    CMP_GE   = 3'd5
  } cmp_e;

  typedef enum logic [VERD_W-1:0] {
    VERD_PASS     = 3'd0,
    VERD_LENGTH   = 3'd1,
    VERD_ALPHA    = 3'd2,
    VERD_DIGIT    = 3'd3,
    VERD_OTHER    = 3'd4,
    VERD_CASE     = 3'd5,
    VERD_TOO_LONG = 3'd6
  } verdict_e;

  // lt/eq describe lhs against rhs; a configured test without a denominator fails
  function automatic logic rule_pass(logic [CODE_W-1:0] code, logic lt, logic eq,
                                     logic den_ok);
    logic pass;
    pass = 1'b1;
    unique case (code)
      CMP_NONE: pass = 1'b1;
      CMP_LT:   pass = den_ok && lt;
      CMP_LE:   pass = den_ok && (lt || eq);
      CMP_EQ:   pass = den_ok && eq;
      CMP_GT:   pass = den_ok && !lt && !eq;
      CMP_GE:   pass = den_ok && !lt;
      default:  pass = 1'b1;
    endcase
    return pass;
  endfunction

endpackage

>>> rtl/core/password_class_ratio_checker_top.sv
// Password class-ratio checker: byte classification, counters and rule verdict.
// Depends on pcrc_pkg.
//
//  channel  | direction | beat payload                        | handshake
//  ---------+-----------+-------------------------------------+--------------------
//  in       | in        | char_byte_i, has_byte_i, is_last_i  | in_valid_i/in_ready_o
//  out      | out       | verdict_o, total_length_o           | out_valid_o/out_ready_i
//  cfg      | in        | cfg_idx_i, cfg_data_i               | cfg_we_i
//
// One beat a cycle unless a stalled result holds a last beat back. A beat is
// registered, then it bumps the class counters; a last beat also runs the four
// cross-multiplied ratio compares and loads the result register, from which its
// verdict shows. A stalled result holds only last beats back; other beats go on.
// Reset clears the counters, the handshake state and the configuration.
module password_class_ratio_checker_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcrc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pcrc_pkg::BYTE_W-1:0]      char_byte_i,
  input  logic                             has_byte_i,
  input  logic                             is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pcrc_pkg::VERD_W-1:0]      verdict_o,
  output logic [pcrc_pkg::TLEN_W-1:0]      total_length_o
);
  import pcrc_pkg::*;

  logic [CODE_W-1:0]  len_test_q;
  logic [LIM_W-1:0]   len_limit_q;
  logic [4*CODE_W-1:0] ratio_tests_q;
  logic [THR_W-1:0]   alpha_thr_q, digit_thr_q, other_thr_q, case_thr_q;

  logic               in_valid_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               has_q, last_q;

  logic [CNT_W-1:0]   len_cnt_q, upper_q, lower_q, digit_q, other_q;
  logic [CNT_W-1:0]   len_cnt_d, upper_d, lower_d, digit_d, other_d;
  logic               ovf_q, ovf_d;

  logic               res_valid_q;
  logic [VERD_W-1:0]  verdict_q, verdict_d;
  logic [TLEN_W-1:0]  tlen_q;

  logic               adv;
  logic               is_upper, is_lower, is_digit;
  logic [CNT_W-1:0]   alpha, diff;
  logic [PROD_W-1:0]  a_lhs, a_rhs, d_lhs, d_rhs, o_lhs, o_rhs, c_lhs, c_rhs;
  logic [LCMP_W-1:0]  len_ext, lim_ext;
  logic               len_ok, alpha_ok, digit_ok, other_ok, case_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_test_q    <= '0;
      len_limit_q   <= '0;
      ratio_tests_q <= '0;
      alpha_thr_q   <= '0;
      digit_thr_q   <= '0;
      other_thr_q   <= '0;
      case_thr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LENGTH_TEST:     len_test_q    <= cfg_data_i[CODE_W-1:0];
        REG_LENGTH_LIMIT:    len_limit_q   <= cfg_data_i[LIM_W-1:0];
        REG_RATIO_TESTS:     ratio_tests_q <= cfg_data_i[4*CODE_W-1:0];
        REG_ALPHA_THRESHOLD: alpha_thr_q   <= cfg_data_i[THR_W-1:0];
        REG_DIGIT_THRESHOLD: digit_thr_q   <= cfg_data_i[THR_W-1:0];
        REG_OTHER_THRESHOLD: other_thr_q   <= cfg_data_i[THR_W-1:0];
        REG_CASE_THRESHOLD:  case_thr_q    <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = in_valid_q && (!last_q || !res_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= char_byte_i;
      has_q  <= has_byte_i;
      last_q <= is_last_i;
    end
  end

  // counters for the beat in the input register
  always_comb begin
    is_upper  = (byte_q >= UPPER_LO) && (byte_q <= UPPER_HI);
    is_lower  = (byte_q >= LOWER_LO) && (byte_q <= LOWER_HI);
    is_digit  = (byte_q >= DIGIT_LO) && (byte_q <= DIGIT_HI);
    len_cnt_d = len_cnt_q;
    upper_d   = upper_q;
    lower_d   = lower_q;
    digit_d   = digit_q;
    other_d   = other_q;
    ovf_d     = ovf_q;
    if (has_q) begin
      if (len_cnt_q >= CNT_W'(MAX_LEN)) begin
        ovf_d = 1'b1;
      end else begin
        len_cnt_d = len_cnt_q + CNT_W'(1);
        priority if (is_upper) upper_d = upper_q + CNT_W'(1);
        else if (is_lower)     lower_d = lower_q + CNT_W'(1);
        else if (is_digit)     digit_d = digit_q + CNT_W'(1);
        else                   other_d = other_q + CNT_W'(1);
      end
    end
  end

  // rules, evaluated on the updated counts
  always_comb begin
    alpha   = upper_d + lower_d;
    diff    = (upper_d >= lower_d) ? (upper_d - lower_d) : (lower_d - upper_d);
    len_ext = LCMP_W'(len_cnt_d);
    lim_ext = LCMP_W'(len_limit_q);
    a_lhs   = PROD_W'({alpha, {FRAC_W{1'b0}}});
    d_lhs   = PROD_W'({digit_d, {FRAC_W{1'b0}}});
    o_lhs   = PROD_W'({other_d, {FRAC_W{1'b0}}});
    c_lhs   = PROD_W'({diff, {FRAC_W{1'b0}}});
    a_rhs   = PROD_W'(alpha_thr_q) * PROD_W'(len_cnt_d);
    d_rhs   = PROD_W'(digit_thr_q) * PROD_W'(len_cnt_d);
    o_rhs   = PROD_W'(other_thr_q) * PROD_W'(len_cnt_d);
    c_rhs   = PROD_W'(case_thr_q) * PROD_W'(alpha);
    len_ok  = rule_pass(len_test_q, len_ext < lim_ext, len_ext == lim_ext, 1'b1);
    alpha_ok = rule_pass(ratio_tests_q[CODE_W-1:0], a_lhs < a_rhs, a_lhs == a_rhs,
                         len_cnt_d != '0);
    digit_ok = rule_pass(ratio_tests_q[2*CODE_W-1:CODE_W], d_lhs < d_rhs,
                         d_lhs == d_rhs, len_cnt_d != '0);
    other_ok = rule_pass(ratio_tests_q[3*CODE_W-1:2*CODE_W], o_lhs < o_rhs,
                         o_lhs == o_rhs, len_cnt_d != '0);
    case_ok  = rule_pass(ratio_tests_q[4*CODE_W-1:3*CODE_W], c_lhs < c_rhs,
                         c_lhs == c_rhs, alpha != '0);
    priority if (ovf_d) verdict_d = VERD_TOO_LONG;
    else if (!len_ok)   verdict_d = VERD_LENGTH;
    else if (!alpha_ok) verdict_d = VERD_ALPHA;
    else if (!digit_ok) verdict_d = VERD_DIGIT;
    else if (!other_ok) verdict_d = VERD_OTHER;
    else if (!case_ok)  verdict_d = VERD_CASE;
    else                verdict_d = VERD_PASS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cnt_q <= '0;
      upper_q   <= '0;
      lower_q   <= '0;
      digit_q   <= '0;
      other_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (adv) begin
      if (last_q) begin
        len_cnt_q <= '0;
        upper_q   <= '0;
        lower_q   <= '0;
        digit_q   <= '0;
        other_q   <= '0;
        ovf_q     <= 1'b0;
      end else begin
        len_cnt_q <= len_cnt_d;
        upper_q   <= upper_d;
        lower_q   <= lower_d;
        digit_q   <= digit_d;
        other_q   <= other_d;
        ovf_q     <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      verdict_q <= verdict_d;
      tlen_q    <= TLEN_W'(len_cnt_d);
    end
  end

  assign out_valid_o    = res_valid_q;
  assign verdict_o      = verdict_q;
  assign total_length_o = tlen_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_cnt_q <= CNT_W'(MAX_LEN))
    else $error("length count beyond limit");

  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+2)'(upper_q) + (CNT_W+2)'(lower_q) + (CNT_W+2)'(digit_q)
      + (CNT_W+2)'(other_q)) == (CNT_W+2)'(len_cnt_q))
    else $error("class counts do not add up to length");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (len_cnt_q == '0 && !ovf_q && out_valid_o))
    else $error("counters not cleared after last beat");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !(adv && last_q))
    else $error("result overwritten while stalled");

endmodule
